>>> rtl/bba_pkg.sv
// Package: shared types, constants and helpers of the bitmap block allocator.
package bba_pkg;

   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;
   localparam int BLOCK_W    = 13;
   localparam int COUNT_W    = 14;
   localparam int WADDR_W    = 8;
   localparam int WCFG_W     = 9;
   localparam int ADDR_WORDS = 256;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] allocated_block;
      status_type         status;
      logic [COUNT_W-1:0] free_blocks;
   } result_type;

   // Index of the lowest set bit; 31 when the word is empty.
   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = BIT_W'(WORD_BITS - 1);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/bba_map_ram.sv
// Module: free-map word memory with per-word valid bits for instant reset.
module bba_map_ram #(
   parameter int USED_WORDS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bba_pkg::ram_req_type          ram_req,
   output logic [bba_pkg::WORD_BITS-1:0] rd_word
);
   import bba_pkg::*;

   localparam int WAW = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;

   logic [WORD_BITS-1:0]  mem [USED_WORDS];
   logic [USED_WORDS-1:0] vld_ff;
   logic [WORD_BITS-1:0]  data_ff;
   logic                  hit_ff;

   // Write the word array
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr[WAW-1:0]] <= ram_req.wr_data;
      end
   end

   // Mark written words; unwritten words read as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            vld_ff[ram_req.wr_addr[WAW-1:0]] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            hit_ff <= vld_ff[ram_req.rd_addr[WAW-1:0]];
         end
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         data_ff <= mem[ram_req.rd_addr[WAW-1:0]];
      end
   end

   assign rd_word = hit_ff ? data_ff : '1;

endmodule

>>> rtl/bba_ctrl.sv
// Module: request sequencer that scans, clears and sets free-map bits.
module bba_ctrl #(
   parameter int USED_WORDS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [bba_pkg::BLOCK_W-1:0]   req_block_number,
   input  logic [bba_pkg::WCFG_W-1:0]    eff_words,
   output bba_pkg::ram_req_type          ram_req,
   input  logic [bba_pkg::WORD_BITS-1:0] rd_word,
   output logic                          res_valid,
   input  logic                          res_take,
   output bba_pkg::result_type           res
);
   import bba_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_SCAN     = 5'b00100,
      S_FREE_WR  = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [WCFG_W-1:0]    ptr_ff, ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [BLOCK_W-1:0]   hint_ff, hint_in;
   result_type           res_ff, res_in;

   logic [COUNT_W-1:0]   limit;
   logic [BLOCK_W-1:0]   hint_dec;
   logic [WADDR_W-1:0]   start_word;
   logic [WCFG_W-1:0]    next_ptr;
   logic [BIT_W-1:0]     found_k;
   logic [BLOCK_W-1:0]   found_blk;
   logic [WORD_BITS-1:0] cleared_word;
   logic [WORD_BITS-1:0] set_word;

   // Derive scan start, limits and bit updates
   always_comb begin
      limit        = {eff_words, 5'b0};
      hint_dec     = hint_ff - BLOCK_W'(1);
      start_word   = (hint_ff == '0) ? '0 : hint_dec[BLOCK_W-1:BIT_W];
      next_ptr     = ptr_ff + WCFG_W'(1);
      found_k      = lowest_bit(rd_word);
      found_blk    = {ptr_ff[WADDR_W-1:0], found_k};
      cleared_word = rd_word & ~(WORD_BITS'(1) << found_k);
      set_word     = rd_word | (WORD_BITS'(1) << blk_ff[BIT_W-1:0]);
   end

   // Sequence one transaction at a time
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      blk_in   = blk_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      hint_in  = hint_ff;
      res_in   = res_ff;
      ram_req  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               blk_in   = req_block_number;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_in.allocated_block = '0;
            res_in.free_blocks     = count_ff;
            if (cmd_ff == CMD_ALLOC) begin
               if (count_ff == '0) begin
                  res_in.status = ST_NO_SPACE;
                  state_in      = S_DONE;
               end else if (WCFG_W'(start_word) >= eff_words) begin
                  res_in.status = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = start_word;
                  ptr_in          = WCFG_W'(start_word);
                  state_in        = S_SCAN;
               end
            end else begin
               if (COUNT_W'(blk_ff) >= limit) begin
                  res_in.status = ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = blk_ff[BLOCK_W-1:BIT_W];
                  state_in        = S_FREE_WR;
               end
            end
         end
         S_SCAN: begin
            // prefetch the following word while the current one is checked
            ram_req.rd_en   = (next_ptr < eff_words) && (rd_word == '0);
            ram_req.rd_addr = next_ptr[WADDR_W-1:0];
            if (rd_word != '0) begin
               ram_req.wr_en          = 1'b1;
               ram_req.wr_addr        = ptr_ff[WADDR_W-1:0];
               ram_req.wr_data        = cleared_word;
               count_in               = count_ff - COUNT_W'(1);
               hint_in                = found_blk;
               res_in.allocated_block = found_blk;
               res_in.status          = ST_OK;
               res_in.free_blocks     = count_in;
               state_in               = S_DONE;
            end else if (next_ptr >= eff_words) begin
               res_in.status = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               ptr_in = next_ptr;
            end
         end
         S_FREE_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = blk_ff[BLOCK_W-1:BIT_W];
            ram_req.wr_data = set_word;
            if (count_ff < limit) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (hint_ff >= blk_ff && blk_ff != '0) begin
               hint_in = blk_ff - BLOCK_W'(1);
            end
            res_in.status      = ST_OK;
            res_in.free_blocks = count_in;
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= COUNT_W'(USED_WORDS * WORD_BITS);
         hint_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hint_ff  <= hint_in;
      end
   end

   // Hold transaction payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      blk_ff <= blk_in;
      ptr_ff <= ptr_in;
      res_ff <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

`ifndef SYNTHESIS
   a_no_rw_same_word: assert property (@(posedge clock) disable iff (reset)
      (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
      else $error("free map read and write hit the same word");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ptr_ff < eff_words))
      else $error("scan pointer past the words in use");

   a_free_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE_WR) |-> $past(ram_req.rd_en))
      else $error("free write-back without a preceding read");

   a_alloc_takes_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && rd_word != '0) |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("allocation did not decrement the free count");
`endif

endmodule

>>> rtl/block_bitmap_allocator.sv
// Module: top level of the bitmap block allocator with CSR and response register.
//
//   Channel  Direction  Handshake          Payload
//   req_     in         valid / stall      cmd, block_number
//   rsp_     out        valid / stall      allocated_block, status, free_blocks
//   csr_     in         valid / ready      bitmap_words
//
// An allocate scans bitmap words one at a time from the hint word through the single
// memory read port, up to the words in use, before its response is registered.
// No-space, not-found-at-start and out-of-range requests need no memory access.
// Reset is immediate: per-word valid bits make unwritten words read as all free.
// A new request is taken while a finished response still waits under rsp_stall.
module block_bitmap_allocator #(
   parameter int MAP_WORDS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [bba_pkg::BLOCK_W-1:0]   req_block_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bba_pkg::BLOCK_W-1:0]   rsp_allocated_block,
   output logic [1:0]                    rsp_status,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_free_blocks,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bba_pkg::WCFG_W-1:0]    csr_bitmap_words
);
   import bba_pkg::*;

   localparam int USED_WORDS = (MAP_WORDS < ADDR_WORDS) ? MAP_WORDS : ADDR_WORDS;

   logic [WCFG_W-1:0]    bitmap_words_ff, bitmap_words_in;
   logic [WCFG_W-1:0]    eff_words;
   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] rd_word;
   logic                 res_valid;
   logic                 res_take;
   result_type           res;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   // Accept register writes
   assign csr_ready       = 1'b1;
   assign bitmap_words_in = (csr_valid && csr_ready) ? csr_bitmap_words : bitmap_words_ff;
   assign eff_words       = (bitmap_words_ff > WCFG_W'(USED_WORDS)) ?
                            WCFG_W'(USED_WORDS) : bitmap_words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_words_ff <= WCFG_W'(ADDR_WORDS);
      end else begin
         bitmap_words_ff <= bitmap_words_in;
      end
   end

   bba_ctrl #(
      .USED_WORDS (USED_WORDS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_block_number (req_block_number),
      .eff_words        (eff_words),
      .ram_req          (ram_req),
      .rd_word          (rd_word),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res              (res)
   );

   bba_map_ram #(
      .USED_WORDS (USED_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_word (rd_word)
   );

   // Load the response register when it is empty or drained this cycle
   always_comb begin
      res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_ff.allocated_block;
   assign rsp_status          = rsp_ff.status;
   assign rsp_free_blocks     = rsp_ff.free_blocks;

`ifndef SYNTHESIS
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("stalled response changed");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_stall)
      else $error("request accepted while a result is pending inside");

   a_ok_alloc_nonzero_or_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NO_SPACE) |-> (rsp_free_blocks == '0))
      else $error("no-space response with free blocks left");
`endif

endmodule
